>>> hw/rtl/pbre_pkg.sv
// Shared types and constants of the base relocation engine.
// Holds command codes, record kinds, stream field offsets and the section entry type.
// Depends on nothing.
package pbre_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_HEADER = 3'd1,
    CMD_RELOC  = 3'd2,
    CMD_V2F    = 3'd3,
    CMD_F2V    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,
    KIND_HL32  = 2'd1,
    KIND_DIR64 = 2'd2,
    KIND_XLAT  = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_NEW_BASE      = 2'd0;
  localparam logic [1:0] REG_IMAGE_BASE    = 2'd1;
  localparam logic [1:0] REG_FILE_ALIGNED  = 2'd2;
  localparam logic [1:0] REG_SECTION_COUNT = 2'd3;

  localparam logic [3:0]  TYPE_DIR64   = 4'd10;
  localparam logic [3:0]  TYPE_HIGHLOW = 4'd3;
  localparam logic [15:0] OFS_MASK     = 16'h0fff;
  localparam int          TYPE_SHIFT   = 12;

  // input tdata layout
  localparam int IN_TDATA_W  = 216;
  localparam int IN_SEC_IDX  = 0;
  localparam int IN_VADDR    = 4;
  localparam int IN_VSIZE    = 36;
  localparam int IN_RAWPTR   = 68;
  localparam int IN_RAWSIZE  = 100;
  localparam int IN_PAGE     = 132;
  localparam int IN_RELOC    = 164;
  localparam int IN_QUERY    = 180;

  // output tdata layout
  localparam int OUT_TDATA_W = 136;

  typedef struct packed {
    logic [31:0] vaddr;
    logic [31:0] vsize;
    logic [31:0] rawptr;
    logic [31:0] rawsize;
  } sect_entry_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } match_res_t;

endpackage

>>> hw/rtl/pbre_sect_mem.sv
// Section table storage: one write port, one read port with registered data.
// Depends on pbre_pkg for the section entry type.
module pbre_sect_mem #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [IW-1:0]          wr_addr,
  input  pbre_pkg::sect_entry_t  wr_data,
  input  logic                   rd_en,
  input  logic [IW-1:0]          rd_addr,
  output pbre_pkg::sect_entry_t  rd_data
);

  pbre_pkg::sect_entry_t mem [DEPTH];
  pbre_pkg::sect_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/pbre_match.sv
// Range check of one section entry and address translation in either direction.
// Depends on pbre_pkg for the entry and result types.
module pbre_match (
  input  logic [31:0]            addr,
  input  logic                   to_virt,
  input  pbre_pkg::sect_entry_t  entry,
  output pbre_pkg::match_res_t   res
);

  logic [31:0] lo;
  logic [31:0] sz;
  logic [31:0] other;
  logic [31:0] hi;

  always_comb begin
    lo    = to_virt ? entry.rawptr  : entry.vaddr;
    sz    = to_virt ? entry.rawsize : entry.vsize;
    other = to_virt ? entry.vaddr   : entry.rawptr;
    // end of range wraps at 32 bits
    hi        = lo + sz;
    res.hit   = (lo <= addr) && (hi > addr);
    res.value = addr - lo + other;
  end

endmodule

>>> hw/rtl/pe_base_relocation_engine.sv
// Top level of the base relocation engine: command decode, table search, result register.
// Depends on pbre_pkg, pbre_sect_mem and pbre_match.
//
// Usage:
//   Input stream in_*: in_tuser carries the command, in_tdata the operand fields.
//   A load transaction writes one section entry, a header transaction sets the page
//   address; neither gives a result. Relocation words and translate requests give one
//   result transaction on out_*, kind in out_tuser.
//   Loads and headers leave the engine idle. A relocation word without file alignment
//   goes from the idle state straight to the done state, which writes the output register.
//   A search reads the section table through its single read port, one entry per cycle,
//   and compares the entry read the cycle before; a search ends early on a hit.
//   One item is worked on at a time; in_tready is high only while the engine is idle.
//   A search may run while the previous result still waits in the output register;
//   the new result then holds until out_tready frees it.
//   Configuration writes on cfg_* take effect at once; the user must make them only while
//   idle, unchecked by the block. Reset (rst_n low, synchronous) clears control state,
//   page address and registers; section entries are undefined until loaded.
module pe_base_relocation_engine #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sec_index, sec_virtual_addr, sec_virtual_size, sec_raw_ptr, sec_raw_size,
  // page_addr, reloc_word, query_addr, zero fill
  input  logic [215:0] in_tdata,
  // cmd
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // patch_offset, delta, translated, hit, zero fill
  output logic [135:0] out_tdata,
  // kind
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CW = $clog2(MAX_SECTIONS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] new_base_r, image_base_r;
  logic        file_aligned_r;
  logic [4:0]  section_count_r;
  logic [31:0] page_r, page_nxt;

  logic [CW-1:0] n_r, n_nxt, rd_idx_r, rd_idx_nxt;
  logic          cmp_valid_r, cmp_valid_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic          to_virt_r, to_virt_nxt;
  logic          need_xlat_r, need_xlat_nxt;
  pbre_pkg::kind_t kind_r, kind_nxt;
  logic          res_hit_r, res_hit_nxt;
  logic [31:0]   res_val_r, res_val_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [31:0]   out_ofs_r, out_ofs_nxt;
  logic [63:0]   out_delta_r, out_delta_nxt;
  logic [31:0]   out_tr_r, out_tr_nxt;
  logic          out_hit_r, out_hit_nxt;

  logic          accept;
  logic          out_free;
  logic          issue;
  logic [CW-1:0] n_cur;
  pbre_pkg::cmd_t cmd;
  logic [15:0]   rword;
  logic [3:0]    rtype;
  logic [31:0]   rofs;

  logic                  wr_en;
  pbre_pkg::sect_entry_t wr_entry;
  pbre_pkg::sect_entry_t rd_entry;
  pbre_pkg::match_res_t  mres;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cmd       = pbre_pkg::cmd_t'(in_tuser);
  assign rword     = in_tdata[pbre_pkg::IN_RELOC +: 16];
  assign rtype     = 4'(rword >> pbre_pkg::TYPE_SHIFT);
  assign rofs      = 32'(rword & pbre_pkg::OFS_MASK) + page_r;
  assign n_cur     = (32'(section_count_r) < 32'(MAX_SECTIONS)) ?
                     CW'(section_count_r) : CW'(MAX_SECTIONS);
  assign issue     = (state_r == S_SEARCH) && (rd_idx_r < n_r);

  assign wr_en = accept && (cmd == pbre_pkg::CMD_LOAD) &&
                 (32'(in_tdata[pbre_pkg::IN_SEC_IDX +: 4]) < 32'(MAX_SECTIONS));
  assign wr_entry.vaddr   = in_tdata[pbre_pkg::IN_VADDR   +: 32];
  assign wr_entry.vsize   = in_tdata[pbre_pkg::IN_VSIZE   +: 32];
  assign wr_entry.rawptr  = in_tdata[pbre_pkg::IN_RAWPTR  +: 32];
  assign wr_entry.rawsize = in_tdata[pbre_pkg::IN_RAWSIZE +: 32];

  pbre_sect_mem #(
    .DEPTH (MAX_SECTIONS),
    .IW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IW'(in_tdata[pbre_pkg::IN_SEC_IDX +: 4])),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (rd_idx_r[IW-1:0]),
    .rd_data (rd_entry)
  );

  pbre_match u_match (
    .addr    (addr_r),
    .to_virt (to_virt_r),
    .entry   (rd_entry),
    .res     (mres)
  );

  always_comb begin
    state_nxt     = state_r;
    page_nxt      = page_r;
    n_nxt         = n_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_valid_nxt = 1'b0;
    addr_nxt      = addr_r;
    to_virt_nxt   = to_virt_r;
    need_xlat_nxt = need_xlat_r;
    kind_nxt      = kind_r;
    res_hit_nxt   = res_hit_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_ofs_nxt   = out_ofs_r;
    out_delta_nxt = out_delta_r;
    out_tr_nxt    = out_tr_r;
    out_hit_nxt   = out_hit_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_idx_nxt  = '0;
          n_nxt       = n_cur;
          res_hit_nxt = 1'b0;
          res_val_nxt = '0;
          case (cmd)
            pbre_pkg::CMD_HEADER: begin
              page_nxt = in_tdata[pbre_pkg::IN_PAGE +: 32];
            end
            pbre_pkg::CMD_RELOC: begin
              addr_nxt      = rofs;
              to_virt_nxt   = 1'b0;
              need_xlat_nxt = file_aligned_r;
              if (rtype == pbre_pkg::TYPE_DIR64) begin
                kind_nxt = pbre_pkg::KIND_DIR64;
              end else if (rtype == pbre_pkg::TYPE_HIGHLOW) begin
                kind_nxt = pbre_pkg::KIND_HL32;
              end else begin
                kind_nxt = pbre_pkg::KIND_SKIP;
              end
              state_nxt = (file_aligned_r && (n_cur != '0)) ? S_SEARCH : S_DONE;
            end
            pbre_pkg::CMD_V2F, pbre_pkg::CMD_F2V: begin
              addr_nxt      = in_tdata[pbre_pkg::IN_QUERY +: 32];
              to_virt_nxt   = (cmd == pbre_pkg::CMD_F2V);
              need_xlat_nxt = 1'b1;
              kind_nxt      = pbre_pkg::KIND_XLAT;
              state_nxt     = (n_cur != '0) ? S_SEARCH : S_DONE;
            end
            default: begin
              // loads go straight to the table; unknown commands drop
            end
          endcase
        end
      end
      S_SEARCH: begin
        // first matching entry wins; entries are compared in index order
        if (cmp_valid_r && mres.hit) begin
          res_hit_nxt = 1'b1;
          res_val_nxt = mres.value;
          state_nxt   = S_DONE;
        end else if (!issue) begin
          state_nxt = S_DONE;
        end else begin
          rd_idx_nxt    = rd_idx_r + CW'(1);
          cmp_valid_nxt = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          if (kind_r == pbre_pkg::KIND_XLAT) begin
            out_ofs_nxt   = '0;
            out_delta_nxt = '0;
            out_tr_nxt    = res_hit_r ? res_val_r : '0;
            out_hit_nxt   = res_hit_r;
          end else begin
            out_tr_nxt  = '0;
            out_hit_nxt = 1'b0;
            if (kind_r == pbre_pkg::KIND_SKIP) begin
              out_ofs_nxt   = '0;
              out_delta_nxt = '0;
            end else begin
              out_ofs_nxt   = need_xlat_r ? (res_hit_r ? res_val_r : '0) : addr_r;
              out_delta_nxt = new_base_r - image_base_r;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      page_r      <= '0;
      n_r         <= '0;
      rd_idx_r    <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      page_r      <= page_nxt;
      n_r         <= n_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    to_virt_r   <= to_virt_nxt;
    need_xlat_r <= need_xlat_nxt;
    kind_r      <= kind_nxt;
    res_hit_r   <= res_hit_nxt;
    res_val_r   <= res_val_nxt;
    out_kind_r  <= out_kind_nxt;
    out_ofs_r   <= out_ofs_nxt;
    out_delta_r <= out_delta_nxt;
    out_tr_r    <= out_tr_nxt;
    out_hit_r   <= out_hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_base_r      <= '0;
      image_base_r    <= '0;
      file_aligned_r  <= 1'b0;
      section_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbre_pkg::REG_NEW_BASE:      new_base_r      <= cfg_wdata;
        pbre_pkg::REG_IMAGE_BASE:    image_base_r    <= cfg_wdata;
        pbre_pkg::REG_FILE_ALIGNED:  file_aligned_r  <= cfg_wdata[0];
        pbre_pkg::REG_SECTION_COUNT: section_count_r <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'b0, out_hit_r, out_tr_r, out_delta_r, out_ofs_r};

  // results are written only from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside done state");

  // the read pointer never passes the number of entries searched
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= n_r)
    else $error("section read pointer past search limit");

  // read data is compared only while a search runs
  a_cmp_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_valid_r |-> (state_r == S_SEARCH))
    else $error("compare pending outside search");

endmodule

>>> verif/pe_base_relocation_engine_test.sv
// Self-checking testbench of the base relocation engine: directed cases, then random streams.
// Predicts each patch or translation record from its own copy of the section table and
// registers. Depends on pbre_pkg and pe_base_relocation_engine.
module pe_base_relocation_engine_test;

  localparam int NUM_SECTIONS  = 16;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = NUM_SECTIONS + 8;
  localparam int TARGET_ITEMS  = 950;
  localparam int LONG_HOLD     = 300;
  localparam int REPORT_LIMIT  = 10;
  localparam int TIMEOUT       = 4_000_000;

  localparam logic [2:0] CMD_RSVD_LO   = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI   = 3'd7;
  localparam logic [3:0] TYPE_ABSOLUTE = 4'd0;

  typedef struct packed {
    pbre_pkg::kind_t kind;
    logic [31:0]     patch_offset;
    logic [63:0]     delta;
    logic [31:0]     translated;
    logic            hit;
  } patch_record_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic [215:0] in_tdata   = '0;
  logic [2:0]   in_tuser   = '0;
  logic         out_tready = 1'b0;
  logic         cfg_we     = 1'b0;
  logic [1:0]   cfg_index  = '0;
  logic [63:0]  cfg_wdata  = '0;
  logic         in_tready;
  logic         out_tvalid;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;

  // predictor state
  logic [31:0] tbl_vaddr   [NUM_SECTIONS];
  logic [31:0] tbl_vsize   [NUM_SECTIONS];
  logic [31:0] tbl_rawptr  [NUM_SECTIONS];
  logic [31:0] tbl_rawsize [NUM_SECTIONS];
  logic [31:0] cur_page     = '0;
  logic [63:0] reloc_new_base   = '0;
  logic [63:0] reloc_image_base = '0;
  logic        xlat_file_aligned = 1'b0;
  logic [4:0]  xlat_count        = '0;

  patch_record_t record_queue[$];
  int mismatches   = 0;
  int items_sent   = 0;
  int sink_wait    = 0;
  int sink_hold    = 0;
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;

  pe_base_relocation_engine #(.MAX_SECTIONS(NUM_SECTIONS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT);
    $display("Verification failed");
    $finish;
  end

  // first matching section wins; the range end wraps at 32 bits
  function automatic pbre_pkg::match_res_t search_table(input bit to_file,
                                                        input logic [31:0] a);
    pbre_pkg::match_res_t m;
    int                   n;
    logic [31:0]          lo;
    logic [31:0]          hi;
    m = '0;
    n = (int'(xlat_count) < NUM_SECTIONS) ? int'(xlat_count) : NUM_SECTIONS;
    for (int i = 0; i < n; i++) begin
      lo = to_file ? tbl_vaddr[i] : tbl_rawptr[i];
      hi = lo + (to_file ? tbl_vsize[i] : tbl_rawsize[i]);
      if (!m.hit && lo <= a && hi > a) begin
        m.hit   = 1'b1;
        m.value = a - lo + (to_file ? tbl_rawptr[i] : tbl_vaddr[i]);
      end
    end
    return m;
  endfunction

  task automatic track_item(input logic [2:0] cmd, input logic [215:0] d);
    patch_record_t        r;
    pbre_pkg::match_res_t m;
    logic [15:0]          word;
    logic [31:0]          ofs;
    logic [3:0]           idx;
    r = '0;
    case (cmd)
      pbre_pkg::CMD_LOAD: begin
        idx = d[pbre_pkg::IN_SEC_IDX +: 4];
        if (int'(idx) < NUM_SECTIONS) begin
          tbl_vaddr[idx]   = d[pbre_pkg::IN_VADDR +: 32];
          tbl_vsize[idx]   = d[pbre_pkg::IN_VSIZE +: 32];
          tbl_rawptr[idx]  = d[pbre_pkg::IN_RAWPTR +: 32];
          tbl_rawsize[idx] = d[pbre_pkg::IN_RAWSIZE +: 32];
        end
      end
      pbre_pkg::CMD_HEADER: cur_page = d[pbre_pkg::IN_PAGE +: 32];
      pbre_pkg::CMD_RELOC: begin
        word = d[pbre_pkg::IN_RELOC +: 16];
        ofs  = 32'(word & pbre_pkg::OFS_MASK) + cur_page;
        if (xlat_file_aligned) begin
          m   = search_table(1'b1, ofs);
          ofs = m.value;
        end
        if ((word >> pbre_pkg::TYPE_SHIFT) == pbre_pkg::TYPE_DIR64)
          r.kind = pbre_pkg::KIND_DIR64;
        else if ((word >> pbre_pkg::TYPE_SHIFT) == pbre_pkg::TYPE_HIGHLOW)
          r.kind = pbre_pkg::KIND_HL32;
        else r.kind = pbre_pkg::KIND_SKIP;
        if (r.kind != pbre_pkg::KIND_SKIP) begin
          r.patch_offset = ofs;
          r.delta        = reloc_new_base - reloc_image_base;
        end
        record_queue.push_back(r);
      end
      pbre_pkg::CMD_V2F, pbre_pkg::CMD_F2V: begin
        m = search_table(cmd == pbre_pkg::CMD_V2F, d[pbre_pkg::IN_QUERY +: 32]);
        r.kind       = pbre_pkg::KIND_XLAT;
        r.translated = m.value;
        r.hit        = m.hit;
        record_queue.push_back(r);
      end
      default: ;
    endcase
  endtask

  // result side: a random stall after each result, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_wait = 0;
      out_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sink_wait = sink_idle_en ? $urandom_range(0, 4) : 0;
      else if (!out_tready && sink_wait > 0) sink_wait = sink_wait - 1;
      out_tready <= (sink_wait == 0);
    end
  end

  always @(posedge clk) begin : result_check
    patch_record_t want;
    patch_record_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind         = pbre_pkg::kind_t'(out_tuser);
      got.patch_offset = out_tdata[31:0];
      got.delta        = out_tdata[95:32];
      got.translated   = out_tdata[127:96];
      got.hit          = out_tdata[128];
      if (record_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected record: kind %0d ofs %h delta %h xlat %h hit %b",
                   $time, got.kind, got.patch_offset, got.delta, got.translated, got.hit);
      end else begin
        want = record_queue.pop_front();
        if (got.kind !== want.kind || got.patch_offset !== want.patch_offset ||
            got.delta !== want.delta || got.translated !== want.translated ||
            got.hit !== want.hit) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] record mismatch: want kind %0d ofs %h delta %h xlat %h hit %b",
                     $time, want.kind, want.patch_offset, want.delta, want.translated,
                     want.hit);
            $display("                        got  kind %0d ofs %h delta %h xlat %h hit %b",
                     got.kind, got.patch_offset, got.delta, got.translated, got.hit);
          end
        end
      end
    end
  end

  function automatic logic [215:0] rand_payload();
    logic [215:0] d;
    int           i;
    for (i = 0; i < 6; i++) d[i*32 +: 32] = $urandom;
    d[192 +: 24] = 24'($urandom);
    return d;
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [215:0] payload);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, payload[211:0]};
    do @(posedge clk); while (!in_tready);
    track_item(cmd, payload);
    if (cmd <= pbre_pkg::CMD_F2V) items_sent++;
  endtask

  task automatic load_item(input logic [3:0] idx, input logic [31:0] va, vs, rp, rs);
    logic [215:0] d;
    d = rand_payload();
    d[pbre_pkg::IN_SEC_IDX +: 4]  = idx;
    d[pbre_pkg::IN_VADDR +: 32]   = va;
    d[pbre_pkg::IN_VSIZE +: 32]   = vs;
    d[pbre_pkg::IN_RAWPTR +: 32]  = rp;
    d[pbre_pkg::IN_RAWSIZE +: 32] = rs;
    send_item(pbre_pkg::CMD_LOAD, d);
  endtask

  task automatic header_item(input logic [31:0] page);
    logic [215:0] d;
    d = rand_payload();
    d[pbre_pkg::IN_PAGE +: 32] = page;
    send_item(pbre_pkg::CMD_HEADER, d);
  endtask

  task automatic reloc_item(input logic [3:0] rtype, input logic [11:0] ofs);
    logic [215:0] d;
    d = rand_payload();
    d[pbre_pkg::IN_RELOC +: 16] = {rtype, ofs};
    send_item(pbre_pkg::CMD_RELOC, d);
  endtask

  task automatic query_item(input logic [2:0] cmd, input logic [31:0] a);
    logic [215:0] d;
    d = rand_payload();
    d[pbre_pkg::IN_QUERY +: 32] = a;
    send_item(cmd, d);
  endtask

  task automatic load_random_section(input logic [3:0] idx);
    if ($urandom_range(0, 7) == 0)
      load_item(idx, $urandom, $urandom, $urandom, $urandom);
    else
      load_item(idx, $urandom & 32'h00FF_F000, $urandom_range(1, 'h4000),
                $urandom & 32'h00FF_FE00, $urandom_range(0, 'h4000));
  endtask

  // hold the input idle until every record is back, then let the engine settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (record_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [63:0] nb, ib, input logic fa,
                                input logic [4:0] cnt);
    cfg_we    <= 1'b1;
    cfg_index <= pbre_pkg::REG_NEW_BASE;
    cfg_wdata <= nb;
    @(posedge clk);
    cfg_index <= pbre_pkg::REG_IMAGE_BASE;
    cfg_wdata <= ib;
    @(posedge clk);
    cfg_index <= pbre_pkg::REG_FILE_ALIGNED;
    cfg_wdata <= {63'b0, fa};
    @(posedge clk);
    cfg_index <= pbre_pkg::REG_SECTION_COUNT;
    cfg_wdata <= {59'b0, cnt};
    @(posedge clk);
    cfg_we <= 1'b0;
    reloc_new_base    = nb;
    reloc_image_base  = ib;
    xlat_file_aligned = fa;
    xlat_count        = cnt;
  endtask

  // nothing loaded yet: relocations, translations and reserved commands with an empty search
  task automatic test_empty_table();
    apply_settings('1, '0, 1'b0, 5'd0);
    reloc_item(pbre_pkg::TYPE_HIGHLOW, 12'hfff);
    reloc_item(pbre_pkg::TYPE_DIR64, 12'h000);
    reloc_item(TYPE_ABSOLUTE, 12'h123);
    query_item(pbre_pkg::CMD_V2F, 32'h0);
    query_item(pbre_pkg::CMD_F2V, 32'hFFFF_FFFF);
    send_item(CMD_RSVD_LO, rand_payload());
    send_item(CMD_RSVD_HI, rand_payload());
    drain();
    // translated relocation with no match gives offset zero
    apply_settings('0, '1, 1'b1, 5'd0);
    reloc_item(pbre_pkg::TYPE_HIGHLOW, 12'h800);
    drain();
  endtask

  // overlapping, wrapping and empty sections; boundaries of each range
  task automatic test_translate_edges();
    load_item(4'd0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0400, 32'h0000_2000);
    load_item(4'd1, 32'h0000_2000, 32'h0000_1000, 32'h0000_3000, 32'h0000_0800);
    load_item(4'd2, 32'hFFFF_F000, 32'h0000_2000, 32'hFFFF_FF00, 32'h0000_0100);
    load_item(4'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0000_0000);
    drain();
    apply_settings(64'h0000_0001_4000_0000, 64'h0000_0000_0040_0000, 1'b0, 5'd4);
    query_item(pbre_pkg::CMD_V2F, 32'h0000_0FFF);
    query_item(pbre_pkg::CMD_V2F, 32'h0000_1000);
    query_item(pbre_pkg::CMD_V2F, 32'h0000_2800);
    query_item(pbre_pkg::CMD_V2F, 32'h0000_3000);
    query_item(pbre_pkg::CMD_V2F, 32'hFFFF_F800);
    query_item(pbre_pkg::CMD_V2F, 32'hFFFF_FFFE);
    query_item(pbre_pkg::CMD_F2V, 32'h0000_3000);
    query_item(pbre_pkg::CMD_F2V, 32'h0000_23FF);
    query_item(pbre_pkg::CMD_F2V, 32'hFFFF_0000);
    drain();
  endtask

  task automatic test_reloc_file_aligned();
    apply_settings(64'h0000_0001_0000_0000, 64'h0000_0000_0040_0000, 1'b1, 5'd4);
    header_item(32'h0000_1000);
    reloc_item(pbre_pkg::TYPE_HIGHLOW, 12'h0ff);
    reloc_item(pbre_pkg::TYPE_DIR64, 12'hfff);
    reloc_item(TYPE_ABSOLUTE, 12'hfff);
    // page plus offset wraps past zero
    header_item(32'hFFFF_FFFF);
    reloc_item(pbre_pkg::TYPE_DIR64, 12'hfff);
    header_item(32'h7FFF_F000);
    reloc_item(pbre_pkg::TYPE_HIGHLOW, 12'hfff);
    drain();
  endtask

  // fill the rest of the table; counts above the table size search all of it
  task automatic test_count_clamp();
    int i;
    for (i = 4; i < NUM_SECTIONS - 1; i++) load_random_section(i[3:0]);
    load_item(4'd15, 32'h4000_0000, 32'h0000_1000, 32'h5000_0000, 32'h0000_1000);
    drain();
    apply_settings('0, '0, 1'b0, 5'd31);
    query_item(pbre_pkg::CMD_V2F, 32'h4000_0800);
    query_item(pbre_pkg::CMD_F2V, 32'h5000_0FFF);
    drain();
    apply_settings(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0, 5'd17);
    query_item(pbre_pkg::CMD_V2F, 32'h4000_0000);
    drain();
    apply_settings('1, '1, 1'b1, 5'd1);
    query_item(pbre_pkg::CMD_V2F, 32'h4000_0000);
    drain();
  endtask

  task automatic test_back_pressure();
    int i;
    apply_settings({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 5'd16);
    src_idle_en = 1'b0;
    sink_hold   = LONG_HOLD;
    for (i = 0; i < 12; i++) begin
      if (i % 3 == 0) query_item(pbre_pkg::CMD_V2F, tbl_vaddr[i % NUM_SECTIONS]);
      else reloc_item(i[0] ? pbre_pkg::TYPE_DIR64 : pbre_pkg::TYPE_HIGHLOW,
                      12'($urandom_range(0, 4095)));
    end
    src_idle_en = 1'b1;
    drain();
  endtask

  task automatic test_sender_pause();
    int i;
    for (i = 0; i < 6; i++) query_item(pbre_pkg::CMD_F2V, tbl_rawptr[i]);
    in_tvalid <= 1'b0;
    while (record_queue.size() != 0) @(posedge clk);
    for (i = 0; i < 6; i++) reloc_item(pbre_pkg::TYPE_HIGHLOW, 12'($urandom_range(0, 4095)));
    drain();
  endtask

  function automatic logic [63:0] pick_wide();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [4:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'($urandom_range(17, 31));
      2:       return 5'd16;
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [31:0] near_addr(input logic [31:0] lo, input logic [31:0] size);
    logic [31:0] a;
    case ($urandom_range(0, 7))
      0:       a = lo - 1;
      1:       a = lo;
      2:       a = lo + size - 1;
      3:       a = lo + size;
      4:       a = $urandom;
      default: a = lo + ((size == 0) ? 32'd0 : $urandom % size);
    endcase
    return a;
  endfunction

  // mostly header-plus-words blocks and targeted queries, some reloads and noise
  task automatic test_random_stream();
    int          pick;
    int          span;
    int          j;
    logic [3:0]  rtype;
    logic [31:0] page;
    while (items_sent < TARGET_ITEMS) begin
      drain();
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      apply_settings(pick_wide(), pick_wide(), 1'($urandom_range(0, 1)), pick_count());
      span = (int'(xlat_count) < NUM_SECTIONS) ? int'(xlat_count) : NUM_SECTIONS;
      repeat ($urandom_range(20, 60)) begin
        pick = $urandom_range(0, 99);
        j    = (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, NUM_SECTIONS - 1);
        if (pick < 6) begin
          load_random_section(4'($urandom_range(0, NUM_SECTIONS - 1)));
        end else if (pick < 16) begin
          if ($urandom_range(0, 4) == 0) page = $urandom;
          else page = (tbl_vaddr[j] & 32'hFFFF_F000) + ($urandom_range(0, 3) << 12);
          header_item(page);
        end else if (pick < 60) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: rtype = pbre_pkg::TYPE_HIGHLOW;
            4, 5, 6, 7: rtype = pbre_pkg::TYPE_DIR64;
            default:    rtype = 4'($urandom);
          endcase
          reloc_item(rtype, 12'($urandom_range(0, 4095)));
        end else if (pick < 76) begin
          query_item(pbre_pkg::CMD_V2F, near_addr(tbl_vaddr[j], tbl_vsize[j]));
        end else if (pick < 92) begin
          query_item(pbre_pkg::CMD_F2V, near_addr(tbl_rawptr[j], tbl_rawsize[j]));
        end else begin
          send_item(3'($urandom_range(0, 7)), rand_payload());
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_translate_edges();
    test_reloc_file_aligned();
    test_count_clamp();
    test_back_pressure();
    test_sender_pause();
    test_random_stream();
    drain();
    if (mismatches == 0 && record_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
